>>> hdl/rcam_pkg.sv
// Shared widths, codes and payload types of the rounded-corner alpha mask.
package rcam_pkg;

	localparam int COORD_W   = 12;  // pixel column / row
	localparam int DIM_W     = 13;  // image width / height register
	localparam int RAD_W     = 20;  // radius, 1/256 pixel
	localparam int CH_W      = 8;   // one colour channel
	localparam int DIST_W    = 21;  // dx, dy, 1/256 pixel
	localparam int SQ_W      = 2 * DIST_W;   // dx^2, dy^2
	localparam int D2_W      = SQ_W + 1;     // dx^2 + dy^2
	localparam int R2_W      = 2 * RAD_W;    // r^2
	localparam int ROOT_W    = (D2_W + 1) / 2;
	localparam int COV_W     = 9;   // coverage 0..256
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMG_W  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_H  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

	localparam logic [RAD_W-1:0] PIX_ONE = 20'd256;  // one pixel in radius units
	localparam logic [COV_W-1:0] COV_ONE = 9'd256;   // full coverage

	typedef enum logic [1:0] {
		CLS_PASS,
		CLS_ZERO,
		CLS_SOFT
	} cls_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} pix_t;

	typedef struct packed {
		logic              byp;  // disabled or outside the corner squares
		logic [RAD_W-1:0]  r;
		logic [DIST_W-1:0] dx;
		logic [DIST_W-1:0] dy;
		pix_t              pix;
	} geo_t;

	typedef struct packed {
		cls_t             cls;
		logic [RAD_W-1:0] r;
		pix_t             pix;
	} side_t;

endpackage

>>> hdl/rcam_ifs.sv
// Request channels of the rounded-corner alpha mask: pixel in, pixel out.
interface rcam_in_if;
	logic                          valid;
	logic                          ready;
	logic [rcam_pkg::COORD_W-1:0]  pixel_col;
	logic [rcam_pkg::COORD_W-1:0]  pixel_row;
	logic [rcam_pkg::CH_W-1:0]     red_in;
	logic [rcam_pkg::CH_W-1:0]     green_in;
	logic [rcam_pkg::CH_W-1:0]     blue_in;
	logic [rcam_pkg::CH_W-1:0]     alpha_in;

	modport source (
		output valid, pixel_col, pixel_row, red_in, green_in, blue_in, alpha_in,
		input  ready
	);
	modport sink (
		input  valid, pixel_col, pixel_row, red_in, green_in, blue_in, alpha_in,
		output ready
	);
endinterface

interface rcam_out_if;
	logic                      valid;
	logic                      ready;
	logic [rcam_pkg::CH_W-1:0] red_out;
	logic [rcam_pkg::CH_W-1:0] green_out;
	logic [rcam_pkg::CH_W-1:0] blue_out;
	logic [rcam_pkg::CH_W-1:0] alpha_out;

	modport source (
		output valid, red_out, green_out, blue_out, alpha_out,
		input  ready
	);
	modport sink (
		input  valid, red_out, green_out, blue_out, alpha_out,
		output ready
	);
endinterface

>>> hdl/rounded_corner_alpha_mask_top.sv
// Top level of the antialiased rounded-corner alpha mask.
// Takes one RGBA pixel per clock, while the skid entry is free, with its
// column and row and rounds the image corners: pixels inside the corner arc
// pass, pixels beyond it become transparent black, and pixels in the
// one-pixel band between have all four channels scaled by coverage (radius
// minus integer distance, 8 fraction bits; products rounded to nearest).
// Throughput is one pixel per clock while the output accepts results; the
// square-root pipeline yields one root bit per stage over a 43-bit squared
// distance. A zero width, height or radius passes every pixel unchanged.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata and must only be
// changed while the pipeline is empty.
module rounded_corner_alpha_mask_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rcam_in_if.sink                         pix_in,
	rcam_out_if.source                      pix_out,
	input  logic                            cfg_we,
	input  logic [rcam_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rcam_pkg::RAD_W-1:0]      cfg_wdata
);
	import rcam_pkg::*;

	// configuration registers, widths masked as written
	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic [RAD_W-1:0]  corner_radius_q;

	// pipeline advance: the whole pipe moves unless the skid entry is occupied
	logic              en;
	logic              full;

	logic              geo_vld;
	geo_t              geo;
	logic              d2_vld;
	logic [D2_W-1:0]   d2;
	side_t             d2_side;
	logic              root_vld;
	logic [ROOT_W-1:0] root;
	side_t             root_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= '0;
			image_height_q  <= '0;
			corner_radius_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IMG_W:  image_width_q   <= cfg_wdata[DIM_W-1:0];
				CFG_IMG_H:  image_height_q  <= cfg_wdata[DIM_W-1:0];
				CFG_RADIUS: corner_radius_q <= cfg_wdata;
				default:    ;  // unmapped index, write dropped
			endcase
		end
	end

	// the output stage holds a result plus one skid entry, so the input side
	// only stalls once a result is already parked behind a waiting output
	assign en = !full;

	// stages 1-2: radius clamp, pixel centre, corner square test, dx/dy
	rcam_geom #(
		.MAX_DIM (MAX_DIM)
	) u_geom (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.pix_in        (pix_in),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.corner_radius (corner_radius_q),
		.geo_vld       (geo_vld),
		.geo           (geo)
	);

	// stages 3-4: squares, distance sum and classification
	rcam_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.geo_vld (geo_vld),
		.geo     (geo),
		.d2_vld  (d2_vld),
		.d2      (d2),
		.side    (d2_side)
	);

	// stages 5-26: floor(sqrt(d2)), only used by soft-band pixels
	rcam_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (d2_vld),
		.in_d2    (d2),
		.in_side  (d2_side),
		.out_vld  (root_vld),
		.out_root (root),
		.out_side (root_side)
	);

	// stage 27 and output: coverage, channel scaling, output/skid registers
	rcam_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (root_vld),
		.in_root (root),
		.in_side (root_side),
		.full    (full),
		.pix_out (pix_out)
	);

endmodule

>>> hdl/rcam_geom.sv
// Stages 1-2: clamped radius, pixel centre, corner test and corner offsets.
module rcam_geom #(
	parameter int MAX_DIM = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	rcam_in_if.sink                     pix_in,
	input  logic [rcam_pkg::DIM_W-1:0]  image_width,
	input  logic [rcam_pkg::DIM_W-1:0]  image_height,
	input  logic [rcam_pkg::RAD_W-1:0]  corner_radius,
	output logic                        geo_vld,
	output rcam_pkg::geo_t              geo
);
	import rcam_pkg::*;

	localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

	logic [16:0]        w_lim, h_lim;
	logic [DIM_W-1:0]   w_sat, h_sat, min_dim;
	logic [RAD_W-1:0]   half, r_clamp;
	logic               disabled;

	logic               vld_s1, byp_s1;
	logic [RAD_W-1:0]   r_s1, fx_s1, fy_s1;
	logic [DIST_W-1:0]  wf_s1, hf_s1;
	pix_t               pix_s1;

	logic               xl, xr, yt, yb;
	logic [DIST_W-1:0]  sum_x, sum_y;
	logic               vld_s2;
	geo_t               geo_s2;

	assign pix_in.ready = en;

	// stage 1: saturate dimensions, clamp radius to half the smaller side
	always_comb begin
		w_lim    = ({4'b0, image_width}  > MAX_DIM_V) ? MAX_DIM_V : {4'b0, image_width};
		h_lim    = ({4'b0, image_height} > MAX_DIM_V) ? MAX_DIM_V : {4'b0, image_height};
		w_sat    = w_lim[DIM_W-1:0];
		h_sat    = h_lim[DIM_W-1:0];
		min_dim  = (w_sat < h_sat) ? w_sat : h_sat;
		half     = {min_dim, 7'b0};
		r_clamp  = (corner_radius < half) ? corner_radius : half;
		disabled = (image_width == '0) || (image_height == '0) || (corner_radius == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s1 <= disabled;
			r_s1   <= r_clamp;
			fx_s1  <= {pix_in.pixel_col, 8'h80};
			fy_s1  <= {pix_in.pixel_row, 8'h80};
			wf_s1  <= {w_sat, 8'h00};
			hf_s1  <= {h_sat, 8'h00};
			pix_s1 <= '{red: pix_in.red_in, green: pix_in.green_in,
				blue: pix_in.blue_in, alpha: pix_in.alpha_in};
		end
	end

	// stage 2: which corner square, offset from the arc centre
	always_comb begin
		sum_x = {1'b0, fx_s1} + {1'b0, r_s1};
		sum_y = {1'b0, fy_s1} + {1'b0, r_s1};
		xl    = fx_s1 < r_s1;
		yt    = fy_s1 < r_s1;
		xr    = sum_x > wf_s1;
		yb    = sum_y > hf_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2.byp <= byp_s1 || !((xl || xr) && (yt || yb));
			geo_s2.r   <= r_s1;
			// left/top win where both sides hit (radius covers the whole side)
			geo_s2.dx  <= xl ? {1'b0, r_s1 - fx_s1} : (sum_x - wf_s1);
			geo_s2.dy  <= yt ? {1'b0, r_s1 - fy_s1} : (sum_y - hf_s1);
			geo_s2.pix <= pix_s1;
		end
	end

	assign geo_vld = vld_s2;
	assign geo     = geo_s2;

endmodule

>>> hdl/rcam_dist.sv
// Stages 3-4: squared distance and radii, then inside / outside / soft band.
module rcam_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        geo_vld,
	input  rcam_pkg::geo_t              geo,
	output logic                        d2_vld,
	output logic [rcam_pkg::D2_W-1:0]   d2,
	output rcam_pkg::side_t             side
);
	import rcam_pkg::*;

	logic [RAD_W-1:0]  r_m1;

	logic              vld_s3, hard_s3, byp_s3;
	logic [SQ_W-1:0]   dxx_s3, dyy_s3;
	logic [R2_W-1:0]   outer2_s3, inner2_s3;
	logic [RAD_W-1:0]  r_s3;
	pix_t              pix_s3;

	logic [D2_W-1:0]   d2_sum, outer2_x, inner2_x;
	cls_t              cls;

	logic              vld_s4;
	logic [D2_W-1:0]   d2_s4;
	side_t             side_s4;

	assign r_m1 = geo.r - PIX_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= geo_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxx_s3    <= geo.dx * geo.dx;
			dyy_s3    <= geo.dy * geo.dy;
			outer2_s3 <= geo.r * geo.r;
			inner2_s3 <= r_m1 * r_m1;
			hard_s3   <= geo.r <= PIX_ONE;
			byp_s3    <= geo.byp;
			r_s3      <= geo.r;
			pix_s3    <= geo.pix;
		end
	end

	always_comb begin
		d2_sum   = {1'b0, dxx_s3} + {1'b0, dyy_s3};
		outer2_x = {{(D2_W-R2_W){1'b0}}, outer2_s3};
		inner2_x = {{(D2_W-R2_W){1'b0}}, inner2_s3};
		if (byp_s3) begin
			cls = CLS_PASS;
		end else if (hard_s3) begin
			cls = (d2_sum <= outer2_x) ? CLS_PASS : CLS_ZERO;
		end else if (d2_sum <= inner2_x) begin
			cls = CLS_PASS;
		end else if (d2_sum >= outer2_x) begin
			cls = CLS_ZERO;
		end else begin
			cls = CLS_SOFT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s4       <= d2_sum;
			side_s4.cls <= cls;
			side_s4.r   <= r_s3;
			side_s4.pix <= pix_s3;
		end
	end

	assign d2_vld = vld_s4;
	assign d2     = d2_s4;
	assign side   = side_s4;

endmodule

>>> hdl/rcam_sqrt.sv
// Pipelined integer square root, one root bit per stage, sideband carried along.
module rcam_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [rcam_pkg::D2_W-1:0]     in_d2,
	input  rcam_pkg::side_t               in_side,
	output logic                          out_vld,
	output logic [rcam_pkg::ROOT_W-1:0]   out_root,
	output rcam_pkg::side_t               out_side
);
	import rcam_pkg::*;

	logic              vld_s  [ROOT_W];
	logic [D2_W-1:0]   rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	side_t             side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int BIT = ROOT_W - 1 - k;

		logic              vld_in;
		logic [D2_W-1:0]   rem_in;
		logic [ROOT_W-1:0] root_in;
		side_t             side_in;
		logic [D2_W:0]     trial;
		logic              take;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = in_d2;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		// (2*root + 2^BIT) * 2^BIT, i.e. (root + 2^BIT)^2 - root^2
		assign trial = ({{(D2_W+1-ROOT_W){1'b0}}, root_in} << (BIT + 1))
			+ ((D2_W+1)'(1) << (2 * BIT));
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? (rem_in - trial[D2_W-1:0]) : rem_in;
				root_s[k] <= take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];
	assign out_side = side_s[ROOT_W-1];

endmodule

>>> hdl/rcam_out.sv
// Coverage stage, channel scaling and the output register with skid entry.
module rcam_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [rcam_pkg::ROOT_W-1:0]   in_root,
	input  rcam_pkg::side_t               in_side,
	output logic                          full,
	rcam_out_if.source                    pix_out
);
	import rcam_pkg::*;

	function automatic logic [CH_W-1:0] scale(input logic [CH_W-1:0] v,
	                                         input logic [CH_W-1:0] cov);
		logic [16:0] prod;
		prod  = 17'(v) * 17'(cov) + 17'd128;
		return prod[15:8];
	endfunction

	logic              below;
	logic [RAD_W-1:0]  diff;
	logic [COV_W-1:0]  cov;
	cls_t              cls_res;

	logic              vld_s27;
	cls_t              cls_s27;
	logic [CH_W-1:0]   cov_s27;
	pix_t              pix_s27;

	pix_t              res;
	logic              take, push;

	logic              out_vld_q, skid_vld_q;
	pix_t              out_q, skid_q;

	// coverage = r - floor(sqrt(d2)), clamped to 0..256
	always_comb begin
		below = in_root < {{(ROOT_W-RAD_W){1'b0}}, in_side.r};
		diff  = in_side.r - in_root[RAD_W-1:0];
		if (!below) begin
			cov = '0;
		end else if (diff > {{(RAD_W-COV_W){1'b0}}, COV_ONE}) begin
			cov = COV_ONE;
		end else begin
			cov = diff[COV_W-1:0];
		end
		cls_res = in_side.cls;
		if (in_side.cls == CLS_SOFT) begin
			if (cov == '0) begin
				cls_res = CLS_ZERO;
			end else if (cov == COV_ONE) begin
				cls_res = CLS_PASS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s27 <= 1'b0;
		end else if (en) begin
			vld_s27 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s27 <= cls_res;
			cov_s27 <= cov[CH_W-1:0];
			pix_s27 <= in_side.pix;
		end
	end

	always_comb begin
		case (cls_s27)
			CLS_PASS: res = pix_s27;
			CLS_SOFT: begin
				res.red   = scale(pix_s27.red,   cov_s27);
				res.green = scale(pix_s27.green, cov_s27);
				res.blue  = scale(pix_s27.blue,  cov_s27);
				res.alpha = scale(pix_s27.alpha, cov_s27);
			end
			default:  res = '0;
		endcase
	end

	assign take = out_vld_q && pix_out.ready;
	assign push = en && vld_s27;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign full              = skid_vld_q;
	assign pix_out.valid     = out_vld_q;
	assign pix_out.red_out   = out_q.red;
	assign pix_out.green_out = out_q.green;
	assign pix_out.blue_out  = out_q.blue;
	assign pix_out.alpha_out = out_q.alpha;

endmodule
